// File: src/lpr_pkg.sv
// Shared constants and types for the LRU page replacement unit.
`default_nettype none
package lpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int IDX_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_BITS  = $clog2(FRAMES + 1);
  localparam int CAP_BITS  = 4;
  localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
  localparam int FAULT_BITS = 32;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(3);

  // register index taken from paddr[2]
  localparam logic REG_FRAME_CAPACITY = 1'b0;

  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [CMP_BITS-1:0]  cmp_t;
  typedef logic [PAGE_BITS-1:0] page_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage
`default_nettype wire

// File: src/lru_page_replacement.sv
// Top level of the LRU page replacement unit: frame scan, recency update, APB register.
`default_nettype none
// One beat on the request side is one page reference; one beat on the response side
// reports hit or fault, the evicted page if any, and the saturating fault count. Page
// numbers live in a single-port synchronous RAM of FRAMES entries; recency ranks and
// valid bits sit in flops. The RAM is read one frame per cycle, the compare works on the
// registered read, and the commit state writes the new ranks and the RAM. The next
// reference is taken in the commit cycle, and while an earlier response still waits in
// the output register. The commit waits only if the output register is still full. The
// user writes frame_capacity (byte address 0, reset 3) only while the unit is idle; the
// block does not enforce it. 0 acts as 1 and values above FRAMES act as FRAMES.
module lru_page_replacement (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [lpr_pkg::PAGE_BITS-1:0] page_number,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic                               page_hit,
  output logic                               evict_valid,
  output logic [lpr_pkg::PAGE_BITS-1:0]      evicted_page,
  output logic [lpr_pkg::FAULT_BITS-1:0]     faults_so_far,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lpr_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [lpr_pkg::DATA_BITS-1:0] pwdata,
  output logic [lpr_pkg::DATA_BITS-1:0]      prdata,
  output logic                               pready
);
  import lpr_pkg::*;

  state_t state, state_next;

  logic [CAP_BITS-1:0]   frame_capacity;
  page_t                 page_mem [FRAMES];
  page_t                 rd_page;
  logic [FRAMES-1:0]     frame_valid;
  idx_t                  frame_rec [FRAMES];
  logic [FAULT_BITS-1:0] fault_total;

  cnt_t  idx;
  page_t page_q;
  logic  hit_found;
  idx_t  hit_idx;
  idx_t  hit_rank;
  logic  victim_found;
  idx_t  victim_idx;
  idx_t  victim_rank;
  page_t victim_page;

  logic  req_accept, rsp_take, commit_go, cfg_write, scan_last, scan_data;
  cnt_t  idx_dec;
  idx_t  cmp_idx;
  cnt_t  valid_count;
  logic  free_found;
  idx_t  free_idx;
  cmp_t  cap_ext, cap_eff;
  logic  fill, evict;
  logic  mem_we;
  idx_t  mem_waddr;
  logic [FAULT_BITS-1:0] fault_next;
  idx_t  rec_next [FRAMES];
  logic [FRAMES-1:0]     valid_next;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_capacity <= CAP_RESET;
    end else if (cfg_write && paddr[2] == REG_FRAME_CAPACITY) begin
      frame_capacity <= pwdata[CAP_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAME_CAPACITY) begin
      prdata = DATA_BITS'(frame_capacity);
    end
  end

  // handshake and sequencing
  assign rsp_take   = rsp_valid && !rsp_stall;
  assign req_accept = req_valid && !req_stall;
  assign scan_last  = (idx == cnt_t'(FRAMES));
  assign scan_data  = (state == ST_SCAN) && (idx != '0);
  assign idx_dec    = idx - cnt_t'(1);
  assign cmp_idx    = idx_dec[IDX_BITS-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) state_next = req_accept ? ST_SCAN : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    commit_go = 1'b0;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
      end
      ST_SCAN: begin
        req_stall = 1'b1;
      end
      ST_COMMIT: begin
        commit_go = !rsp_valid || !rsp_stall;
        req_stall = !commit_go;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // page RAM
  always_ff @(posedge clk) begin
    if (mem_we) page_mem[mem_waddr] <= page_q;
    else        rd_page <= page_mem[idx[IDX_BITS-1:0]];
  end

  // scan: one frame per cycle, compare against the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      hit_found    <= 1'b0;
      victim_found <= 1'b0;
    end else if (req_accept) begin
      idx          <= '0;
      hit_found    <= 1'b0;
      victim_found <= 1'b0;
    end else if (state == ST_SCAN) begin
      idx <= idx + cnt_t'(1);
      if (scan_data && frame_valid[cmp_idx]) begin
        if (!hit_found && rd_page == page_q) begin
          hit_found <= 1'b1;
        end
        if (!victim_found || frame_rec[cmp_idx] > victim_rank) begin
          victim_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      page_q <= page_number[PAGE_BITS-1:0];
    end
    if (scan_data && frame_valid[cmp_idx]) begin
      if (!hit_found && rd_page == page_q) begin
        hit_idx  <= cmp_idx;
        hit_rank <= frame_rec[cmp_idx];
      end
      if (!victim_found || frame_rec[cmp_idx] > victim_rank) begin
        victim_idx  <= cmp_idx;
        victim_rank <= frame_rec[cmp_idx];
        victim_page <= rd_page;
      end
    end
  end

  // commit decision
  always_comb begin
    valid_count = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      valid_count = valid_count + cnt_t'(frame_valid[k]);
      if (!frame_valid[k]) begin
        free_found = 1'b1;
        free_idx   = idx_t'(k);
      end
    end
  end

  always_comb begin
    cap_ext = cmp_t'(frame_capacity);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = cmp_t'(1);
    end else if (cap_ext > cmp_t'(FRAMES)) begin
      cap_eff = cmp_t'(FRAMES);
    end
  end

  assign fill  = !hit_found && free_found && (cmp_t'(valid_count) < cap_eff);
  assign evict = !hit_found && !fill && victim_found;

  assign mem_we    = commit_go && (fill || evict);
  assign mem_waddr = fill ? free_idx : victim_idx;

  always_comb begin
    fault_next = fault_total;
    if (!hit_found && fault_total != '1) begin
      fault_next = fault_total + FAULT_BITS'(1);
    end
  end

  // recency ageing, all frames in parallel
  always_comb begin
    valid_next = frame_valid;
    for (int k = 0; k < FRAMES; k++) begin
      rec_next[k] = frame_rec[k];
      if (frame_valid[k] && (!hit_found || frame_rec[k] < hit_rank)) begin
        rec_next[k] = frame_rec[k] + idx_t'(1);
      end
    end
    if (hit_found) begin
      rec_next[hit_idx] = '0;
    end else if (fill) begin
      rec_next[free_idx]   = '0;
      valid_next[free_idx] = 1'b1;
    end else if (evict) begin
      rec_next[victim_idx] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      fault_total <= '0;
      for (int k = 0; k < FRAMES; k++) frame_rec[k] <= '0;
    end else if (commit_go) begin
      frame_valid <= valid_next;
      fault_total <= fault_next;
      for (int k = 0; k < FRAMES; k++) frame_rec[k] <= rec_next[k];
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      page_hit      <= hit_found;
      evict_valid   <= evict;
      evicted_page  <= evict ? victim_page : '0;
      faults_so_far <= fault_next;
    end
  end

  a_hit_rank_zero: assert property (@(posedge clk) disable iff (rst)
    commit_go && hit_found |=> frame_rec[$past(hit_idx)] == '0)
    else $error("hit frame not made most recent");

  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (frame_valid & $past(frame_valid)) == $past(frame_valid))
    else $error("resident frame dropped");

  a_evict_on_fault: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && evict_valid |-> !page_hit)
    else $error("eviction reported on a hit");

  a_fault_monotonic: assert property (@(posedge clk) disable iff (rst)
    commit_go |=> fault_total >= $past(fault_total))
    else $error("fault count went down");

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the LRU page replacement unit: references, recency, capacity.
`timescale 1ns / 1ps
module tb;
  import lpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CHUNK = 100;
  localparam logic [ADDR_BITS-1:0] CAP_ADDR = {REG_FRAME_CAPACITY, 2'b00};
  localparam logic [ADDR_BITS-1:0] UNUSED_ADDR = {~REG_FRAME_CAPACITY, 2'b00};

  typedef struct packed {
    logic                  hit;
    logic                  evict;
    page_t                 evicted;
    logic [FAULT_BITS-1:0] faults;
  } lru_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  page_t page_number = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic page_hit;
  logic evict_valid;
  page_t evicted_page;
  logic [FAULT_BITS-1:0] faults_so_far;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;

  lru_page_replacement dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .page_number(page_number),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .page_hit(page_hit), .evict_valid(evict_valid), .evicted_page(evicted_page),
    .faults_so_far(faults_so_far),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  page_t                 held_page [FRAMES];
  bit                    held_valid [FRAMES];
  int unsigned           held_rank [FRAMES];
  logic [FAULT_BITS-1:0] fault_count = '0;
  logic [CAP_BITS-1:0]   capacity_reg = CAP_RESET;

  lru_outcome_t outstanding[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int refs_sent = 0;
  int hits_predicted = 0;
  int evictions_predicted = 0;
  int settings_used = 0;
  int setting_no = 0;
  page_t work_set [12];
  int work_size = 1;

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      held_valid[i] = 1'b0;
      held_rank[i] = 0;
      held_page[i] = '0;
    end
  end

  function automatic lru_outcome_t reference_page(page_t pg);
    lru_outcome_t r;
    int resident, hit_at, free_at, victim, eff;
    int unsigned hit_rank;
    r = '0;
    resident = 0;
    hit_at = -1;
    free_at = -1;
    victim = -1;
    for (int i = 0; i < FRAMES; i++) begin
      if (held_valid[i]) begin
        resident++;
        if (hit_at < 0 && held_page[i] == pg) hit_at = i;
        if (victim < 0 || held_rank[i] > held_rank[victim]) victim = i;
      end else if (free_at < 0) begin
        free_at = i;
      end
    end
    eff = (capacity_reg == 0) ? 1 : ((capacity_reg > FRAMES) ? FRAMES : int'(capacity_reg));
    if (hit_at >= 0) begin
      r.hit = 1'b1;
      hit_rank = held_rank[hit_at];
      for (int i = 0; i < FRAMES; i++)
        if (held_valid[i] && held_rank[i] < hit_rank) held_rank[i]++;
      held_rank[hit_at] = 0;
    end else begin
      if (fault_count != '1) fault_count++;
      if (resident < eff && free_at >= 0) begin
        for (int i = 0; i < FRAMES; i++)
          if (held_valid[i]) held_rank[i]++;
        held_valid[free_at] = 1'b1;
        held_page[free_at] = pg;
        held_rank[free_at] = 0;
      end else if (victim >= 0) begin
        r.evict = 1'b1;
        r.evicted = held_page[victim];
        for (int i = 0; i < FRAMES; i++)
          if (held_valid[i]) held_rank[i]++;
        held_page[victim] = pg;
        held_rank[victim] = 0;
      end
    end
    r.faults = fault_count;
    return r;
  endfunction

  function automatic void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  task automatic send_page(input page_t pg);
    lru_outcome_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    page_number <= pg;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    r = reference_page(pg);
    outstanding.push_back(r);
    refs_sent++;
    if (r.hit) hits_predicted++;
    if (r.evict) evictions_predicted++;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (outstanding.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr == CAP_ADDR) begin
      capacity_reg = data[CAP_BITS-1:0];
      settings_used++;
    end
  endtask

  task automatic check_capacity();
    logic [DATA_BITS-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CAP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== DATA_BITS'(capacity_reg))
      report_mismatch("frame_capacity read", 64'(capacity_reg), 64'(got));
  endtask

  task automatic set_capacity(input logic [DATA_BITS-1:0] data);
    drain();
    write_reg(CAP_ADDR, data);
    check_capacity();
  endtask

  function automatic page_t pick_page();
    if ($urandom_range(99) < 75) return work_set[$urandom_range(work_size - 1)];
    return page_t'($urandom_range(65535));
  endfunction

  // response checker and receiver stall
  always @(posedge clk) begin
    lru_outcome_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (outstanding.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: response beat with nothing outstanding", $realtime);
        end else begin
          want = outstanding.pop_front();
          if (page_hit !== want.hit)
            report_mismatch("page_hit", 64'(want.hit), 64'(page_hit));
          if (evict_valid !== want.evict)
            report_mismatch("evict_valid", 64'(want.evict), 64'(evict_valid));
          if (evicted_page !== want.evicted)
            report_mismatch("evicted_page", 64'(want.evicted), 64'(evicted_page));
          if (faults_so_far !== want.faults)
            report_mismatch("faults_so_far", 64'(want.faults), 64'(faults_so_far));
        end
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_reset_and_register();
    check_capacity();
    write_reg(UNUSED_ADDR, 32'h0000_0005);
    check_capacity();
  endtask

  // capacity 0 behaves as a single frame; done first while no frame is resident
  task automatic test_capacity_zero();
    set_capacity(32'h0);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hFFFF);
    send_page(16'h0000);
  endtask

  task automatic test_capacity_above_frames();
    page_t fill [7];
    fill = '{16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h1234};
    set_capacity(32'hFFFF_FFFF);
    foreach (fill[i]) send_page(fill[i]);
    send_page(16'h0000);
    send_page(16'h4321);
  endtask

  // resident count stays above capacity; faults replace LRU
  task automatic test_capacity_lowered();
    set_capacity(32'h1);
    send_page(16'h8000);
    send_page(16'h9999);
    send_page(16'h5555);
    send_page(16'h0001);
  endtask

  task automatic test_random_refs(input int n, input int snd_pct, input int rcv_pct);
    logic [CAP_BITS-1:0] cap;
    logic [DATA_BITS-1:0] junk;
    int eff;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int c = 0; c < n / CHUNK; c++) begin
      case (setting_no % 6)
        0: cap = CAP_BITS'(1);
        1: cap = CAP_BITS'(FRAMES);
        2: cap = '1;
        3: cap = '0;
        default: cap = CAP_BITS'($urandom_range(2, FRAMES - 1));
      endcase
      setting_no++;
      junk = $urandom();
      set_capacity({junk[DATA_BITS-1:CAP_BITS], cap});
      eff = (cap == 0) ? 1 : ((cap > FRAMES) ? FRAMES : int'(cap));
      work_size = eff + $urandom_range(0, 3);
      for (int i = 0; i < work_size; i++) work_set[i] = page_t'($urandom_range(65535));
      work_set[0] = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      repeat (CHUNK) send_page(pick_page());
    end
  endtask

  // receiver holds off long enough for the unit to back up onto its input
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    hold_left = 400;
    repeat (30) send_page(pick_page());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 32;
    recv_idle_pct = 56;
    test_reset_and_register();
    test_capacity_zero();
    test_capacity_above_frames();
    test_capacity_lowered();
    test_random_refs(600, 32, 56);
    test_output_holdoff();
    test_random_refs(600, 56, 32);
    test_random_refs(600, 0, 0);
    drain();
    repeat (FRAMES + 4) @(posedge clk);
    if (outstanding.size() != 0) begin
      mismatches += outstanding.size();
      $display("%0d responses never arrived", outstanding.size());
    end
    $display("%0d references: %0d hits, %0d evictions, %0d faults, %0d capacity writes",
             refs_sent, hits_predicted, evictions_predicted, fault_count, settings_used);
    $display("idle patterns on both sides, output hold-off, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
